// File: hdl/prt_pkg.sv
// Package for the priority request table: sizes, operation and status codes,
// item structs and the control/status structs between the sequencer and lists.
// Used by prt_list and priority_request_table_core.
package prt_pkg;

    localparam int NUM_LISTS      = 4;
    localparam int SLOTS_PER_LIST = 16;
    localparam int SERVED_LEVELS  = 4;
    localparam int MAX_RESULTS    = 4;

    localparam int NAME_W  = 8;
    localparam int PRIO_W  = 4;
    localparam int SLOT_IW = $clog2(SLOTS_PER_LIST);
    localparam int SCNT_W  = $clog2(SLOTS_PER_LIST + 1);
    localparam int LIST_IW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int K_W     = $clog2(MAX_RESULTS + 1);

    // Operation codes carried in the func field.
    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_SERVE  = 2'd1,
        FN_UPDATE = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    // Result status codes.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        func_t             func;
        logic [NAME_W-1:0] req_name;
        logic [PRIO_W-1:0] req_priority;
    } cmd_item_t;

    typedef struct packed {
        logic [NAME_W-1:0] out_name;
        logic [PRIO_W-1:0] out_priority;
        logic [1:0]        out_list;
        logic [1:0]        status;
        logic              last;
    } rsp_item_t;

    // One slot as stored in a list memory.
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Sequencer to list.
    typedef struct packed {
        logic [SLOT_IW-1:0] rd_addr;
        logic               scan_en;
        logic               scan_start;
        func_t              mode;
        logic [NAME_W-1:0]  key_name;
        logic [PRIO_W-1:0]  key_prio;
        logic               add_wr;
        logic [SLOT_IW-1:0] add_addr;
        logic               rm_en;
        logic               clear_all;
    } list_ctl_t;

    // List to sequencer: scan results.
    typedef struct packed {
        logic               free_found;
        logic [SLOT_IW-1:0] free_idx;
        logic               best_found;
        logic [PRIO_W-1:0]  best_prio;
        logic [NAME_W-1:0]  best_name;
    } list_stat_t;

    // List number reduced to the two bits of the out_list field.
    function automatic logic [1:0] to_out_list(input logic [LIST_IW-1:0] l);
        logic [LIST_IW+1:0] w;
        w = {2'b00, l};
        return w[1:0];
    endfunction

endpackage

// File: hdl/prt_list.sv
// One list of request slots: slot memory, occupancy bits and the compare unit
// that is stepped over the slots one per cycle by the sequencer.
// Depends on prt_pkg.
module prt_list
    import prt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  list_ctl_t  ctl,
    output list_stat_t stat
);

    entry_t slot_mem [SLOTS_PER_LIST];

    entry_t                    rd_data_reg;
    logic [SLOT_IW-1:0]        addr_d_reg;
    logic                      rd_vld_reg;
    logic [SLOTS_PER_LIST-1:0] occ_reg, occ_next;

    logic               free_found_reg, free_found_next;
    logic [SLOT_IW-1:0] free_idx_reg, free_idx_next;
    logic               best_found_reg, best_found_next;
    logic [PRIO_W-1:0]  best_prio_reg, best_prio_next;
    logic [SLOT_IW-1:0] best_idx_reg, best_idx_next;
    logic [NAME_W-1:0]  best_name_reg, best_name_next;

    logic               occ_d;
    logic               upd_hit;
    logic               wr_en;
    logic [SLOT_IW-1:0] wr_addr;
    entry_t             wr_data;

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[ctl.rd_addr];
    end

    assign occ_d   = occ_reg[addr_d_reg];
    assign upd_hit = rd_vld_reg && (ctl.mode == FN_UPDATE) && occ_d &&
                     (rd_data_reg.name == ctl.key_name);

    // Write port: an add from the sequencer or an update hit from the scan.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_d_reg;
        wr_data = '{name: rd_data_reg.name, prio: ctl.key_prio};
        if (ctl.add_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = ctl.add_addr;
            wr_data = '{name: ctl.key_name, prio: ctl.key_prio};
        end
        else if (upd_hit)
        begin
            wr_en = 1'b1;
        end
    end

    // Occupancy bits: a slot is occupied when its priority is nonzero.
    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.clear_all)
        begin
            occ_next = '0;
        end
        if (ctl.add_wr)
        begin
            occ_next[ctl.add_addr] = (ctl.key_prio != '0);
        end
        if (upd_hit)
        begin
            occ_next[addr_d_reg] = (ctl.key_prio != '0);
        end
        if (ctl.rm_en)
        begin
            occ_next[best_idx_reg] = 1'b0;
        end
    end

    // Compare unit: tracks the first free slot and the first slot at the
    // most urgent served level seen so far.
    always_comb
    begin
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_prio_next  = best_prio_reg;
        best_idx_next   = best_idx_reg;
        best_name_next  = best_name_reg;
        if (ctl.scan_start)
        begin
            free_found_next = 1'b0;
            best_found_next = 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if ((ctl.mode == FN_ADD) && !free_found_reg && !occ_d)
            begin
                free_found_next = 1'b1;
                free_idx_next   = addr_d_reg;
            end
            if ((ctl.mode == FN_SERVE) && occ_d &&
                (rd_data_reg.prio != '0) &&
                (rd_data_reg.prio <= PRIO_W'(SERVED_LEVELS)) &&
                (!best_found_reg || (rd_data_reg.prio < best_prio_reg)))
            begin
                best_found_next = 1'b1;
                best_prio_next  = rd_data_reg.prio;
                best_idx_next   = addr_d_reg;
                best_name_next  = rd_data_reg.name;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg     <= 1'b0;
            addr_d_reg     <= '0;
            occ_reg        <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            best_prio_reg  <= '0;
            best_idx_reg   <= '0;
            best_name_reg  <= '0;
        end
        else
        begin
            rd_vld_reg     <= ctl.scan_en;
            addr_d_reg     <= ctl.rd_addr;
            occ_reg        <= occ_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            best_found_reg <= best_found_next;
            best_prio_reg  <= best_prio_next;
            best_idx_reg   <= best_idx_next;
            best_name_reg  <= best_name_next;
        end
    end

    assign stat.free_found = free_found_reg;
    assign stat.free_idx   = free_idx_reg;
    assign stat.best_found = best_found_reg;
    assign stat.best_prio  = best_prio_reg;
    assign stat.best_name  = best_name_reg;

endmodule

// File: hdl/priority_request_table_core.sv
// Top level of the priority request table: command sequencer, list
// instances and the result register. Depends on prt_pkg and prt_list.
//
//   channel | signals                     | moves
//   --------+-----------------------------+---------------------------------
//   command | cmd_valid, cmd_ready, cmd   | one operation item (cmd_item_t)
//   result  | rsp_valid, rsp_ready, rsp   | one result item (rsp_item_t)
//
// Add, serve and update scan all lists side by side, one slot per cycle,
// before the first result is loaded. Serve then walks the lists in order
// up to its last hit, waiting while the result register is full.
// Reset clears the occupancy bits at once; there is no clearing pass.
// The block accepts one item at a time; cmd_ready is high only when idle.
// A stalled result holds in the result register and stops the sequencer
// only when it has another result to load.
module priority_request_table_core
    import prt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [SCNT_W-1:0]  cnt_reg, cnt_next;
    func_t              func_reg, func_next;
    logic [NAME_W-1:0]  name_reg, name_next;
    logic [PRIO_W-1:0]  prio_reg, prio_next;
    logic [PRIO_W-1:0]  level_reg, level_next;
    logic [NUM_LISTS-1:0] hit_reg, hit_next;
    logic [LIST_IW-1:0] lst_reg, lst_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [K_W-1:0]     n_reg, n_next;
    logic               out_valid_reg, out_valid_next;
    rsp_item_t          out_reg, out_next;

    list_ctl_t  ctl  [NUM_LISTS];
    list_stat_t stat [NUM_LISTS];

    logic                 out_free;
    logic                 cmd_acc;
    logic                 lvl_found;
    logic [PRIO_W-1:0]    lvl;
    logic [NUM_LISTS-1:0] hit_vec;
    logic [K_W-1:0]       hit_cnt;
    logic                 add_found;
    logic [LIST_IW-1:0]   add_list;
    logic [NUM_LISTS-1:0] found_vec;

    // List slices.
    for (genvar g = 0; g < NUM_LISTS; g++)
    begin : g_list
        prt_list u_list (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl[g]),
            .stat  (stat[g])
        );
        assign found_vec[g] = stat[g].best_found;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd_valid && cmd_ready;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Most urgent served level over all lists, and the lists that hold it,
    // capped to the first MAX_RESULTS in list order.
    always_comb
    begin
        lvl_found = 1'b0;
        lvl       = '0;
        hit_vec   = '0;
        hit_cnt   = '0;
        for (int l = 0; l < NUM_LISTS; l++)
        begin
            if (stat[l].best_found && (!lvl_found || (stat[l].best_prio < lvl)))
            begin
                lvl_found = 1'b1;
                lvl       = stat[l].best_prio;
            end
        end
        for (int l = 0; l < NUM_LISTS; l++)
        begin
            if (stat[l].best_found && (stat[l].best_prio == lvl) &&
                (hit_cnt < K_W'(MAX_RESULTS)))
            begin
                hit_vec[l] = 1'b1;
                hit_cnt    = hit_cnt + K_W'(1);
            end
        end
    end

    // Lowest list with a free slot.
    always_comb
    begin
        add_found = 1'b0;
        add_list  = '0;
        for (int l = NUM_LISTS - 1; l >= 0; l--)
        begin
            if (stat[l].free_found)
            begin
                add_found = 1'b1;
                add_list  = LIST_IW'(l);
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        func_next      = func_reg;
        name_next      = name_reg;
        prio_next      = prio_reg;
        level_next     = level_reg;
        hit_next       = hit_reg;
        lst_next       = lst_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;

        for (int l = 0; l < NUM_LISTS; l++)
        begin
            ctl[l].rd_addr    = cnt_reg[SLOT_IW-1:0];
            ctl[l].scan_en    = 1'b0;
            ctl[l].scan_start = cmd_acc;
            ctl[l].mode       = func_reg;
            ctl[l].key_name   = name_reg;
            ctl[l].key_prio   = prio_reg;
            ctl[l].add_wr     = 1'b0;
            ctl[l].add_addr   = stat[l].free_idx;
            ctl[l].rm_en      = 1'b0;
            ctl[l].clear_all  = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    func_next = cmd.func;
                    name_next = cmd.req_name;
                    prio_next = cmd.req_priority;
                    cnt_next  = '0;
                    state_next = (cmd.func == FN_CLEAR) ? S_DECIDE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (cnt_reg == SCNT_W'(SLOTS_PER_LIST))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    for (int l = 0; l < NUM_LISTS; l++)
                    begin
                        ctl[l].scan_en = 1'b1;
                    end
                    cnt_next = cnt_reg + SCNT_W'(1);
                end
            end

            S_DECIDE:
            begin
                if ((func_reg == FN_SERVE) && lvl_found)
                begin
                    level_next = lvl;
                    hit_next   = hit_vec;
                    n_next     = hit_cnt;
                    k_next     = '0;
                    lst_next   = '0;
                    state_next = S_EMIT;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_name: '0, out_priority: '0,
                                       out_list: 2'b00, status: STAT_DONE,
                                       last: 1'b1};
                    state_next     = S_IDLE;
                    case (func_reg)
                        FN_ADD:
                        begin
                            if (add_found)
                            begin
                                ctl[add_list].add_wr = 1'b1;
                                out_next.out_list    = to_out_list(add_list);
                            end
                            else
                            begin
                                out_next.status = STAT_FULL;
                            end
                        end
                        FN_SERVE:
                        begin
                            out_next.status = STAT_EMPTY;
                        end
                        FN_CLEAR:
                        begin
                            for (int l = 0; l < NUM_LISTS; l++)
                            begin
                                ctl[l].clear_all = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_next.status = STAT_DONE;
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                if (!hit_reg[lst_reg])
                begin
                    lst_next = lst_reg + LIST_IW'(1);
                end
                else if (out_free)
                begin
                    ctl[lst_reg].rm_en = 1'b1;
                    out_valid_next     = 1'b1;
                    out_next           = '{out_name: stat[lst_reg].best_name,
                                           out_priority: level_reg,
                                           out_list: to_out_list(lst_reg),
                                           status: STAT_DONE,
                                           last: (k_reg == n_reg - K_W'(1))};
                    k_next   = k_reg + K_W'(1);
                    lst_next = lst_reg + LIST_IW'(1);
                    if (k_reg == n_reg - K_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            func_reg      <= FN_ADD;
            name_reg      <= '0;
            prio_reg      <= '0;
            level_reg     <= '0;
            hit_reg       <= '0;
            lst_reg       <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            func_reg      <= func_next;
            name_reg      <= name_next;
            prio_reg      <= prio_next;
            level_reg     <= level_next;
            hit_reg       <= hit_next;
            lst_reg       <= lst_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

`ifndef SYNTHESIS
    // Every list picked for serving still holds an entry at the served level.
    a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ((hit_reg & ~found_vec) == '0))
        else $error("serve hit on a list without an entry");

    // The serve walk never emits more results than it counted.
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (k_reg < n_reg))
        else $error("serve result count overrun");

    // Full and empty reports are single results.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != STAT_DONE)) |-> out_reg.last)
        else $error("error result without last");

    // The scan counter stops at the list length.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= SCNT_W'(SLOTS_PER_LIST)))
        else $error("scan counter past list end");
`endif

endmodule
